// ===== hw/rtl/hsw_pkg.sv =====
// Shared types, constants and helper functions for the heartbeat supervised watchdog.
// Used by hsw_ctrl, hsw_dp and the top level heartbeat_supervised_watchdog.
// Depends on nothing else.
`default_nettype none

package hsw_pkg;

   // Default values for the top level parameters.
   localparam int DEF_NUM_TASKS  = 4;
   localparam int DEF_TIME_WIDTH = 32;

   // Fixed field widths.
   localparam int MODE_W    = 2;
   localparam int TASK_W    = 4;
   localparam int CNT_W     = 12;
   localparam int PCODE_W   = 3;
   localparam int PERIOD_W  = 16;
   localparam int TMO_W     = 16;
   localparam int PRESC_W   = 8;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 16;

   // Item modes.
   localparam logic [MODE_W-1:0] MODE_SYS_TICK  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_HEARTBEAT = 2'd1;
   localparam logic [MODE_W-1:0] MODE_LS_TICK   = 2'd2;
   localparam logic [MODE_W-1:0] MODE_FEED      = 2'd3;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_RELOAD  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PRESC   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_PERIOD  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_TIMEOUT = 2'd3;

   // Configuration reset values.
   localparam logic [CNT_W-1:0]    RST_RELOAD  = 12'd4095;
   localparam logic [PCODE_W-1:0]  RST_PRESC   = 3'd4;
   localparam logic [PERIOD_W-1:0] RST_PERIOD  = 16'd100;
   localparam logic [TMO_W-1:0]    RST_TIMEOUT = 16'd500;

   // Largest prescale code in use; higher codes divide as this one.
   localparam logic [PCODE_W-1:0] PCODE_MAX = 3'd6;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;  // take the input word and apply its immediate effects
      logic scan;    // compare one heartbeat stamp
      logic push;    // move the finished result into the output register
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_check;   // the offered word is a system tick that starts a check
      logic scan_last;  // this scan step ends the check
   } status_type;

   // Prescaler divisor: 4 shifted left by the code, codes above six act as six.
   function automatic logic [PRESC_W:0] presc_div(input logic [PCODE_W-1:0] code);
      logic [PCODE_W-1:0] c;
      begin
         c = (code > PCODE_MAX) ? PCODE_MAX : code;
         return (PRESC_W+1)'(4) << c;
      end
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/heartbeat_supervised_watchdog.sv =====
// Heartbeat supervised watchdog, top level; instantiates hsw_ctrl and hsw_dp, uses hsw_pkg.
// A word that starts no check goes from accept through the push state to the output
// register; a check word first scans k tasks (1 to NUM_TASKS), as the stamp compare
// unit examines one task per cycle. A new word is taken only after the previous one is
// pushed; the push waits while the output register is held. Synchronous active-high
// reset clears time, stamps, counters, config and valid, not result data; no clearing pass.
`default_nettype none

module heartbeat_supervised_watchdog #(
   parameter int NUM_TASKS  = hsw_pkg::DEF_NUM_TASKS,
   parameter int TIME_WIDTH = hsw_pkg::DEF_TIME_WIDTH
) (
   input  logic                             clock,
   input  logic                             reset,
   // Input word channel.
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [hsw_pkg::MODE_W-1:0]       req_mode,
   input  logic [hsw_pkg::TASK_W-1:0]       req_task_id,
   // Result word channel.
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_system_reset,
   output logic                             rsp_check_done,
   output logic                             rsp_all_alive,
   output logic [hsw_pkg::TASK_W-1:0]       rsp_stuck_task,
   output logic [hsw_pkg::CNT_W-1:0]        rsp_counter_value,
   // Configuration write channel.
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [hsw_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [hsw_pkg::CSR_DAT_W-1:0]    csr_wdata
);
   import hsw_pkg::*;

   cmd_type    cmd;
   status_type status;

   // Configuration writes are always taken; they are only to be issued while the
   // block is idle; the block does not enforce this and has no interlock with words.
   assign csr_ready = 1'b1;

   // The controller accepts a word only when idle, runs the stamp scan for
   // check words one task per cycle, then hands the result to the output
   // register once that register is free. The output register lets the next
   // word be accepted while a finished result still waits downstream.
   hsw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // The datapath holds configuration, time, per-task stamps, prescaler and
   // down counter. Immediate effects of a word (time advance, stamping,
   // prescaled count, feed, expiry) are applied in the accept cycle; a check
   // then compares the age of each stamp against the timeout in task order
   // and stops at the first stale task.
   hsw_dp #(
      .NUM_TASKS  (NUM_TASKS),
      .TIME_WIDTH (TIME_WIDTH)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .req_mode          (req_mode),
      .req_task_id       (req_task_id),
      .csr_write         (csr_valid && csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .cmd               (cmd),
      .status            (status),
      .rsp_system_reset  (rsp_system_reset),
      .rsp_check_done    (rsp_check_done),
      .rsp_all_alive     (rsp_all_alive),
      .rsp_stuck_task    (rsp_stuck_task),
      .rsp_counter_value (rsp_counter_value)
   );

`ifndef SYNTHESIS
   // Once a word is taken, the block stalls requests in the next cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("word accepted while previous word still in progress");

   // All alive is only reported together with a completed check.
   a_alive_needs_check: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_all_alive) |-> rsp_check_done)
      else $error("all_alive set without a check");

   // A stuck task is reported only by a check that found a stale task.
   a_stuck_only_on_fail: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (!rsp_check_done || rsp_all_alive)) |-> (rsp_stuck_task == '0))
      else $error("stuck_task nonzero without a failed check");

   // A reported stuck task is always a monitored task.
   a_stuck_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ({1'b0, rsp_stuck_task} < (TASK_W+1)'(NUM_TASKS)))
      else $error("stuck_task outside the monitored tasks");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/hsw_ctrl.sv =====
// Controller state machine of the heartbeat supervised watchdog.
// Sequences accept, stamp scan and result hand-off; depends on hsw_pkg.
`default_nettype none

module hsw_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   input  hsw_pkg::status_type status,
   output hsw_pkg::cmd_type    cmd
);
   import hsw_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_PUSH = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in   = state_ff;
      cmd.accept = 1'b0;
      cmd.scan   = 1'b0;
      cmd.push   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = status.is_check ? ST_SCAN : ST_PUSH;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (status.scan_last) begin
               state_in = ST_PUSH;
            end
         end
         ST_PUSH: begin
            if (out_free) begin
               cmd.push = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.push) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/hsw_dp.sv =====
// Datapath of the heartbeat supervised watchdog: registers, time, stamps,
// prescaler, down counter, stamp compare and output register; depends on hsw_pkg.
`default_nettype none

module hsw_dp #(
   parameter int NUM_TASKS  = hsw_pkg::DEF_NUM_TASKS,
   parameter int TIME_WIDTH = hsw_pkg::DEF_TIME_WIDTH
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [hsw_pkg::MODE_W-1:0]       req_mode,
   input  logic [hsw_pkg::TASK_W-1:0]       req_task_id,
   input  logic                             csr_write,
   input  logic [hsw_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [hsw_pkg::CSR_DAT_W-1:0]    csr_wdata,
   input  hsw_pkg::cmd_type                 cmd,
   output hsw_pkg::status_type              status,
   output logic                             rsp_system_reset,
   output logic                             rsp_check_done,
   output logic                             rsp_all_alive,
   output logic [hsw_pkg::TASK_W-1:0]       rsp_stuck_task,
   output logic [hsw_pkg::CNT_W-1:0]        rsp_counter_value
);
   import hsw_pkg::*;

   localparam int IDX_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;

   // Configuration registers.
   logic [CNT_W-1:0]    reload_ff;
   logic [PCODE_W-1:0]  pcode_ff;
   logic [PERIOD_W-1:0] period_cfg_ff;
   logic [TMO_W-1:0]    timeout_ff;

   // Working state.
   logic [TIME_WIDTH-1:0] time_ff,   time_in;
   logic [TIME_WIDTH-1:0] stamp_ff  [NUM_TASKS];
   logic [TIME_WIDTH-1:0] stamp_in  [NUM_TASKS];
   logic [PERIOD_W-1:0]   period_ff, period_in;
   logic [PRESC_W-1:0]    presc_ff,  presc_in;
   logic [CNT_W-1:0]      cnt_ff,    cnt_in;
   logic [IDX_W-1:0]      idx_ff,    idx_in;

   // Pending result.
   logic              res_rst_ff,   res_rst_in;
   logic              res_done_ff,  res_done_in;
   logic              res_alive_ff, res_alive_in;
   logic [TASK_W-1:0] res_stuck_ff, res_stuck_in;

   // Output register.
   logic              out_rst_ff;
   logic              out_done_ff;
   logic              out_alive_ff;
   logic [TASK_W-1:0] out_stuck_ff;
   logic [CNT_W-1:0]  out_cnt_ff;

   logic [PERIOD_W-1:0]   period_next;
   logic                  check_hit;
   logic [PRESC_W:0]      presc_next;
   logic                  presc_wrap;
   logic                  task_ok;
   logic [TIME_WIDTH-1:0] age;
   logic                  stale;
   logic                  idx_last;

   assign period_next = period_ff + PERIOD_W'(1);
   assign check_hit   = (req_mode == MODE_SYS_TICK) && (period_next >= period_cfg_ff);
   assign presc_next  = {1'b0, presc_ff} + (PRESC_W+1)'(1);
   assign presc_wrap  = (presc_next >= presc_div(pcode_ff));
   assign task_ok     = ({1'b0, req_task_id} < (TASK_W+1)'(NUM_TASKS));
   assign age         = time_ff - stamp_ff[idx_ff];
   assign stale       = (age > TIME_WIDTH'(timeout_ff));
   assign idx_last    = (idx_ff == IDX_W'(NUM_TASKS - 1));

   assign status.is_check  = check_hit;
   assign status.scan_last = stale || idx_last;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         reload_ff     <= RST_RELOAD;
         pcode_ff      <= RST_PRESC;
         period_cfg_ff <= RST_PERIOD;
         timeout_ff    <= RST_TIMEOUT;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_RELOAD:  reload_ff     <= csr_wdata[CNT_W-1:0];
            REG_PRESC:   pcode_ff      <= csr_wdata[PCODE_W-1:0];
            REG_PERIOD:  period_cfg_ff <= csr_wdata[PERIOD_W-1:0];
            REG_TIMEOUT: timeout_ff    <= csr_wdata[TMO_W-1:0];
            default:     ;
         endcase
      end
   end

   always_comb begin
      time_in      = time_ff;
      stamp_in     = stamp_ff;
      period_in    = period_ff;
      presc_in     = presc_ff;
      cnt_in       = cnt_ff;
      idx_in       = idx_ff;
      res_rst_in   = res_rst_ff;
      res_done_in  = res_done_ff;
      res_alive_in = res_alive_ff;
      res_stuck_in = res_stuck_ff;
      if (cmd.accept) begin
         res_rst_in   = 1'b0;
         res_done_in  = 1'b0;
         res_alive_in = 1'b0;
         res_stuck_in = '0;
         idx_in       = '0;
         unique case (req_mode)
            MODE_SYS_TICK: begin
               time_in   = time_ff + TIME_WIDTH'(1);
               period_in = check_hit ? '0 : period_next;
            end
            MODE_HEARTBEAT: begin
               if (task_ok) begin
                  stamp_in[req_task_id[IDX_W-1:0]] = time_ff;
               end
            end
            MODE_LS_TICK: begin
               if (presc_wrap) begin
                  presc_in = '0;
                  if (cnt_ff <= CNT_W'(1)) begin
                     // Expiry: flag reset, reload and restamp every task.
                     res_rst_in = 1'b1;
                     cnt_in     = reload_ff;
                     for (int i = 0; i < NUM_TASKS; i++) begin
                        stamp_in[i] = time_ff;
                     end
                  end else begin
                     cnt_in = cnt_ff - CNT_W'(1);
                  end
               end else begin
                  presc_in = presc_next[PRESC_W-1:0];
               end
            end
            default: begin
               cnt_in = reload_ff;
            end
         endcase
      end else if (cmd.scan) begin
         if (stale) begin
            res_done_in  = 1'b1;
            res_alive_in = 1'b0;
            res_stuck_in = TASK_W'(idx_ff);
         end else if (idx_last) begin
            res_done_in  = 1'b1;
            res_alive_in = 1'b1;
            cnt_in       = reload_ff;
         end else begin
            idx_in = idx_ff + IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         time_ff   <= '0;
         period_ff <= '0;
         presc_ff  <= '0;
         cnt_ff    <= RST_RELOAD;
         idx_ff    <= '0;
         for (int i = 0; i < NUM_TASKS; i++) begin
            stamp_ff[i] <= '0;
         end
      end else begin
         time_ff   <= time_in;
         period_ff <= period_in;
         presc_ff  <= presc_in;
         cnt_ff    <= cnt_in;
         idx_ff    <= idx_in;
         stamp_ff  <= stamp_in;
      end
   end

   always_ff @(posedge clock) begin
      res_rst_ff   <= res_rst_in;
      res_done_ff  <= res_done_in;
      res_alive_ff <= res_alive_in;
      res_stuck_ff <= res_stuck_in;
      if (cmd.push) begin
         out_rst_ff   <= res_rst_ff;
         out_done_ff  <= res_done_ff;
         out_alive_ff <= res_alive_ff;
         out_stuck_ff <= res_stuck_ff;
         out_cnt_ff   <= cnt_ff;
      end
   end

   assign rsp_system_reset  = out_rst_ff;
   assign rsp_check_done    = out_done_ff;
   assign rsp_all_alive     = out_alive_ff;
   assign rsp_stuck_task    = out_stuck_ff;
   assign rsp_counter_value = out_cnt_ff;

endmodule

`default_nettype wire
